/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL files that check their own logic.
// Every macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the condition holds, the consequence holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/bmm_pkg.sv */
package bmm_pkg;

  localparam int ELEM_BITS = 16;
  localparam int PROD_BITS = 2 * ELEM_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam int OUT_BITS  = 34;
  localparam int REG_BITS  = 4;
  localparam int ROW_BITS  = 3;
  localparam int IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic [ROW_BITS-1:0] row;
    logic [ROW_BITS-1:0] col;
    logic                slast;
  } mac_tag_t;

  typedef struct packed {
    mac_tag_t tag;
    logic     wr_a;
    logic     wr_b;
  } ctrl_cmd_t;

  function automatic logic [OUT_BITS-1:0] sat_product(input logic signed [ACC_BITS-1:0] a);
    logic [OUT_BITS-1:0] r;
    if (a[ACC_BITS-1] != a[OUT_BITS-1]) begin
      r = a[ACC_BITS-1] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
    end else begin
      r = a[OUT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/batched_matrix_multiply.sv */
// Batched matrix multiply for signed Q8.8 elements. Each slice takes A (rows_a by inner_dim)
// and then B (inner_dim by cols_b), row-major, one element per transfer and one transfer per
// cycle. The last element of B starts the product, and the slave side takes no transfer while
// the one shared multiply-accumulate pipeline works through it, one product a cycle unless a
// waiting result stalls it. Each result passes the read, multiply, accumulate and output
// registers and leaves row-major as a saturated Q18.16 sum, with row and column, and tlast on
// the final element of the slice. With the reset shape of 8 by 8 by 8 a slice loads 128
// elements and issues 512 products. The next slice can load while the last results drain. A
// stalled master side holds the whole pipeline. Dimension registers read as 1 when zero and
// saturate at MAX_DIM.
`include "assert_macros.svh"

module batched_matrix_multiply import bmm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [REG_BITS-1:0]  cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ELEM_BITS-1:0] s_tdata,  // element_value
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,  // product_value, out_row, out_col
  output logic                 m_tlast
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctrl_cmd_t     cmd;
  logic          advance;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;

  bmm_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .advance   (advance),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .a_addr    (a_addr),
    .b_addr    (b_addr)
  );

  bmm_datapath #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .a_addr   (a_addr),
    .b_addr   (b_addr),
    .wr_data  (s_tdata),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `ASSERT_ALWAYS(a_no_load_in_compute, !(s_tready && cmd.tag.valid), "load during compute")
  `ASSERT_IMPLIES(a_stall_cause, !advance, m_tvalid && !m_tready, "stall without backpressure")
  `ASSERT_IMPLIES(a_slast_ends_sum, cmd.tag.valid && cmd.tag.slast, cmd.tag.last, "bad slice end")

endmodule

/* rtl/core/bmm_ctrl.sv */
module bmm_ctrl import bmm_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int AW      = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0] cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                advance,
  output ctrl_cmd_t           cmd,
  output logic [AW-1:0]       wr_addr,
  output logic [AW-1:0]       a_addr,
  output logic [AW-1:0]       b_addr
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  localparam logic ST_LOAD    = 1'b0;
  localparam logic ST_COMPUTE = 1'b1;

  logic                state;
  logic [REG_BITS-1:0] rows_a;
  logic [REG_BITS-1:0] inner_dim;
  logic [REG_BITS-1:0] cols_b;
  logic [CW-1:0]       load_count;
  logic [CW-1:0]       count_next;
  logic                loading_b;
  logic [DIM_W-1:0]    m;
  logic [DIM_W-1:0]    k;
  logic [DIM_W-1:0]    n;
  logic [CW-1:0]       size_a;
  logic [CW-1:0]       size_b;
  logic [DIM_W-1:0]    r;
  logic [DIM_W-1:0]    c;
  logic [DIM_W-1:0]    i;
  logic [AW-1:0]       a_base;
  logic [AW-1:0]       a_ptr;
  logic [AW-1:0]       b_ptr;
  logic                last_i;
  logic                last_c;
  logic                last_r;
  logic                accept;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_BITS-1:0] d);
    logic [DIM_W-1:0] v;
    if (d == '0) begin
      v = DIM_W'(1);
    end else if (d > REG_BITS'(MAX_DIM)) begin
      v = DIM_W'(MAX_DIM);
    end else begin
      v = DIM_W'(d);
    end
    return v;
  endfunction

  assign m = clamp_dim(rows_a);
  assign k = clamp_dim(inner_dim);
  assign n = clamp_dim(cols_b);
  assign size_a = CW'(m) * CW'(k);
  assign size_b = CW'(k) * CW'(n);

  assign s_tready   = (state == ST_LOAD);
  assign accept     = s_tvalid && s_tready;
  assign count_next = load_count + CW'(1);

  assign last_i = (i + DIM_W'(1)) == k;
  assign last_c = (c + DIM_W'(1)) == n;
  assign last_r = (r + DIM_W'(1)) == m;

  always_comb begin
    cmd           = '0;
    cmd.wr_a      = accept && !loading_b;
    cmd.wr_b      = accept && loading_b;
    cmd.tag.valid = (state == ST_COMPUTE);
    cmd.tag.first = (i == '0);
    cmd.tag.last  = last_i;
    cmd.tag.row   = ROW_BITS'(r);
    cmd.tag.col   = ROW_BITS'(c);
    cmd.tag.slast = last_i && last_c && last_r;
  end

  assign wr_addr = load_count[AW-1:0];
  assign a_addr  = a_ptr;
  assign b_addr  = b_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= REG_BITS'(MAX_DIM);
      inner_dim <= REG_BITS'(MAX_DIM);
      cols_b    <= REG_BITS'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      loading_b  <= 1'b0;
      r          <= '0;
      c          <= '0;
      i          <= '0;
      a_base     <= '0;
      a_ptr      <= '0;
      b_ptr      <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (!loading_b) begin
              if (count_next >= size_a) begin
                loading_b  <= 1'b1;
                load_count <= '0;
              end else begin
                load_count <= count_next;
              end
            end else if (count_next >= size_b) begin
              loading_b  <= 1'b0;
              load_count <= '0;
              state      <= ST_COMPUTE;
              r          <= '0;
              c          <= '0;
              i          <= '0;
              a_base     <= '0;
              a_ptr      <= '0;
              b_ptr      <= '0;
            end else begin
              load_count <= count_next;
            end
          end
        end
        ST_COMPUTE: begin
          if (advance) begin
            if (!last_i) begin
              i     <= i + DIM_W'(1);
              a_ptr <= a_ptr + AW'(1);
              b_ptr <= b_ptr + AW'(n);
            end else begin
              i <= '0;
              if (!last_c) begin
                c     <= c + DIM_W'(1);
                a_ptr <= a_base;
                b_ptr <= AW'(c) + AW'(1);
              end else begin
                c     <= '0;
                b_ptr <= '0;
                if (!last_r) begin
                  r      <= r + DIM_W'(1);
                  a_base <= a_base + AW'(k);
                  a_ptr  <= a_base + AW'(k);
                end else begin
                  state <= ST_LOAD;
                end
              end
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* rtl/core/bmm_datapath.sv */
module bmm_datapath import bmm_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int AW      = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  input  logic [AW-1:0]        wr_addr,
  input  logic [AW-1:0]        a_addr,
  input  logic [AW-1:0]        b_addr,
  input  logic [ELEM_BITS-1:0] wr_data,
  output logic                 advance,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,
  output logic                 m_tlast
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [ELEM_BITS-1:0]        a_mem [DEPTH];
  logic [ELEM_BITS-1:0]        b_mem [DEPTH];
  logic signed [ELEM_BITS-1:0] rd_a;
  logic signed [ELEM_BITS-1:0] rd_b;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  mac_tag_t                    tag1;
  mac_tag_t                    tag2;
  mac_tag_t                    tag3;
  logic                        done;
  logic [OUT_BITS-1:0]         out_value;
  logic [ROW_BITS-1:0]         out_row;
  logic [ROW_BITS-1:0]         out_col;
  logic                        out_last;

  assign advance = !(done && m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[wr_addr] <= wr_data;
    end
    if (cmd.wr_b) begin
      b_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_a <= a_mem[a_addr];
      rd_b <= b_mem[b_addr];
      prod <= rd_a * rd_b;
      if (tag2.valid) begin
        acc <= tag2.first ? ACC_BITS'(prod) : acc + ACC_BITS'(prod);
      end
      tag3 <= tag2;
    end
    if (done && advance) begin
      out_value <= sat_product(acc);
      out_row   <= tag3.row;
      out_col   <= tag3.col;
      out_last  <= tag3.slast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1     <= '0;
      tag2     <= '0;
      done     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        tag1 <= cmd.tag;
        tag2 <= tag1;
        done <= tag2.valid && tag2.last;
      end
      if (done && advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {out_col, out_row, out_value};
  assign m_tlast = out_last;

endmodule
